// ===== rtl/fgn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_pkg: shared types and constants of the fractal gradient noise pipeline
// Fixed-point widths, hash constants, the quarter-wave sine table and the
// item structs used between the pipeline modules.
// ----------------------------------------------------------------------------
package fgn_pkg;

  localparam int COORD_SPAN = 256;
  localparam int OCTAVES    = 12;
  localparam int ANGLE_BITS = 10;

  localparam int COORD_W = 8;
  localparam int SEED_W  = 19;
  localparam int DIV_W   = 8;
  localparam int FRAC_W  = 16;
  localparam int HASH_W  = 32;

  // Quotient of (coordinate << (FRAC_W + OCTAVES - 1)) / divisor.
  localparam int QW       = COORD_W + FRAC_W + OCTAVES - 1;
  localparam int DIV_BPS  = 5;
  localparam int DIV_STAGES = (QW + DIV_BPS - 1) / DIV_BPS;
  localparam int DIV_DW   = DIV_STAGES * DIV_BPS;

  localparam logic [HASH_W-1:0] HASH_MUL_A = 32'd2048419325;
  localparam logic [HASH_W-1:0] HASH_MUL_B = 32'd1911520717;
  localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0]       ONE_Q30 = 64'd1 << 30;

  localparam int QB      = ANGLE_BITS - 2;
  localparam int QTR     = 1 << QB;
  localparam int MAG_W   = 15;
  localparam int GRAD_W  = 16;
  localparam int GRAD_FRAC = 14;
  localparam int DOT_W   = 20;
  localparam int FADE_W  = 17;
  localparam int NW      = 24;
  localparam int SUM_W   = NW + 4;
  localparam int ONE_Q16 = 65536;

  localparam int OCT_STAGES  = 10;
  localparam int POST_STAGES = 6;
  localparam int LATENCY     = DIV_STAGES + OCT_STAGES + POST_STAGES;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 19;
  localparam logic [SEED_W-1:0] SEED_RESET  = 19'd1;
  localparam logic [DIV_W-1:0]  SCALE_RESET = 8'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HASH_SEED = 1'b0,
    REG_SCALE_DIV = 1'b1
  } cfg_reg_t;

  localparam int LEVELS = 6;
  localparam logic [7:0] LVL_THR [LEVELS-1] = '{8'd42, 8'd84, 8'd126, 8'd168, 8'd210};
  localparam logic [2:0] LEVEL_MAX = 3'd5;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
  } in_t;

  typedef struct packed {
    logic [7:0] height;
    logic [2:0] level;
  } out_t;

  // Lattice position of one octave.
  typedef struct packed {
    logic [HASH_W-1:0] x0;
    logic [HASH_W-1:0] y0;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } oct_pos_t;

  typedef logic [MAG_W-1:0] sin_tbl_t [QTR+1];

  // Quarter-wave sine magnitude in Q14, worked out at elaboration.
  function automatic sin_tbl_t build_sin_tbl();
    sin_tbl_t   tbl;
    logic [63:0] x, x2, t, s, m;
    for (int r = 0; r <= QTR; r++) begin
      x  = (64'(r) * HALF_PI_Q30) >> QB;
      x2 = (x * x) >> 30;
      t  = ONE_Q30 - x2 / 72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      m  = (s + 64'd32768) >> 16;
      if (m > 64'd16384) m = 64'd16384;
      tbl[r] = MAG_W'(m);
    end
    return tbl;
  endfunction

  localparam sin_tbl_t SIN_TBL = build_sin_tbl();

  function automatic logic [HASH_W-1:0] rot16(logic [HASH_W-1:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  // Signed Q14 gradient component for a quadrant and an offset within it.
  function automatic logic signed [GRAD_W-1:0] grad_of(logic [1:0] quad,
                                                       logic [QB-1:0] r);
    logic [QB:0]               rr;
    logic signed [GRAD_W-1:0]  g;
    rr = quad[0] ? ((QB+1)'(QTR) - {1'b0, r}) : {1'b0, r};
    g  = $signed({1'b0, SIN_TBL[rr]});
    return quad[1] ? -g : g;
  endfunction

endpackage

// ===== rtl/fgn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_div: pipelined restoring divider for sample positions
// Divides coordinate << (FRAC_W + OCTAVES - 1) by the scale divisor, a few
// quotient bits per stage. Each octave takes its position from the top bits.
// ----------------------------------------------------------------------------
module fgn_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [fgn_pkg::COORD_W-1:0] coord,
  input  logic [fgn_pkg::DIV_W-1:0]   divisor,
  output logic                       out_valid,
  output logic [fgn_pkg::QW-1:0]      quot
);
  import fgn_pkg::*;

  logic              v_r   [DIV_STAGES];
  logic [DIV_DW-1:0] num_r [DIV_STAGES];
  logic [DIV_W-1:0]  rem_r [DIV_STAGES];
  logic [DIV_DW-1:0] num_nxt [DIV_STAGES];
  logic [DIV_W-1:0]  rem_nxt [DIV_STAGES];

  // The numerator register shifts out dividend bits at the top and takes
  // quotient bits in at the bottom.
  always_comb begin
    logic [DIV_DW-1:0] num;
    logic [DIV_W:0]    w;
    logic [DIV_W-1:0]  rem;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        num = DIV_DW'(coord) << (QW - COORD_W);
        rem = '0;
      end else begin
        num = num_r[s-1];
        rem = rem_r[s-1];
      end
      for (int i = 0; i < DIV_BPS; i++) begin
        w   = {rem, num[DIV_DW-1]};
        num = num << 1;
        if (w >= {1'b0, divisor}) begin
          w      = w - {1'b0, divisor};
          num[0] = 1'b1;
        end
        rem = w[DIV_W-1:0];
      end
      num_nxt[s] = num;
      rem_nxt[s] = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) v_r[s] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int s = 1; s < DIV_STAGES; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      num_r[s] <= num_nxt[s];
      rem_r[s] <= rem_nxt[s];
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign quot      = num_r[DIV_STAGES-1][QW-1:0];

endmodule

// ===== rtl/fgn_octave.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_octave: one octave of gradient noise
// Hashes the four lattice corners, looks up their gradients, forms the dot
// products and blends them with the smoothstep fade, over ten stages.
// ----------------------------------------------------------------------------
module fgn_octave (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  fgn_pkg::oct_pos_t              pos,
  input  logic [fgn_pkg::SEED_W-1:0]     seed,
  output logic                           out_valid,
  output logic signed [fgn_pkg::NW-1:0]  noise
);
  import fgn_pkg::*;

  localparam int DP_W = FRAC_W + 1 + GRAD_W + 1;
  localparam int DF_W = DOT_W + 1;
  localparam int P1_W = DF_W + FADE_W + 1;
  localparam int P2_W = NW + 1 + FADE_W + 1;
  localparam logic [FRAC_W+1:0] FADE_K = 18'd196608;

  logic [OCT_STAGES-1:0] v_r;

  // Stage 1: x hashes and squared fractions.
  logic [HASH_W-1:0] ha1_r [2];
  logic [HASH_W-1:0] y0_1_r;
  logic [FRAC_W-1:0] fx_1_r, fy_1_r, w2x_1_r, w2y_1_r;
  // Stage 2: mixed y hashes and fades.
  logic [HASH_W-1:0] ha2_r [2];
  logic [HASH_W-1:0] hb2_r [4];
  logic [FRAC_W-1:0] fx_2_r, fy_2_r;
  logic [FADE_W-1:0] sx_2_r, sy_2_r;
  // Stage 3: final hashes.
  logic [HASH_W-1:0] hc3_r [4];
  logic [FRAC_W-1:0] fx_3_r, fy_3_r;
  logic [FADE_W-1:0] sx_3_r, sy_3_r;
  // Stage 4: gradients.
  logic signed [GRAD_W-1:0] gx4_r [4];
  logic signed [GRAD_W-1:0] gy4_r [4];
  logic [FRAC_W-1:0] fx_4_r, fy_4_r;
  logic [FADE_W-1:0] sx_4_r, sy_4_r;
  // Stage 5: corner dot products.
  logic signed [DOT_W-1:0] dot5_r [4];
  logic [FADE_W-1:0] sx_5_r, sy_5_r;
  // Stage 6: x differences.
  logic signed [DOT_W-1:0] a06_r [2];
  logic signed [DF_W-1:0]  df6_r [2];
  logic [FADE_W-1:0] sx_6_r, sy_6_r;
  // Stage 7: x products.
  logic signed [DOT_W-1:0] a07_r [2];
  logic signed [P1_W-1:0]  p7_r [2];
  logic [FADE_W-1:0] sy_7_r;
  // Stage 8: top row and y difference.
  logic signed [NW-1:0]   top8_r;
  logic signed [NW:0]     df8_r;
  logic [FADE_W-1:0] sy_8_r;
  // Stage 9: y product.
  logic signed [NW-1:0]   top9_r;
  logic signed [P2_W-1:0] p9_r;
  // Stage 10: octave value.
  logic signed [NW-1:0]   noise_r;

  logic [HASH_W-1:0] ha1_nxt [2];
  logic [HASH_W-1:0] hb2_nxt [4];
  logic [HASH_W-1:0] hc3_nxt [4];
  logic signed [GRAD_W-1:0] gx4_nxt [4];
  logic signed [GRAD_W-1:0] gy4_nxt [4];
  logic signed [DOT_W-1:0]  dot5_nxt [4];
  logic [31:0] sqx, sqy;
  logic [FRAC_W+FADE_W:0] fpx, fpy;

  always_comb begin
    logic [HASH_W-1:0] cx, cy;
    logic [ANGLE_BITS-1:0] idx;
    logic signed [FRAC_W:0] dx, dy;
    logic signed [DP_W-1:0] dsum;
    for (int i = 0; i < 2; i++) begin
      cx = (i == 0) ? pos.x0 : pos.x0 + HASH_W'(1);
      ha1_nxt[i] = cx * HASH_W'(seed);
    end
    for (int c = 0; c < 4; c++) begin
      cy = c[1] ? y0_1_r + HASH_W'(1) : y0_1_r;
      hb2_nxt[c] = (cy ^ rot16(ha1_r[c[0]])) * HASH_MUL_B;
      hc3_nxt[c] = (ha2_r[c[0]] ^ rot16(hb2_r[c])) * HASH_MUL_A;
      idx = hc3_r[c][HASH_W-1 -: ANGLE_BITS];
      gx4_nxt[c] = grad_of(idx[ANGLE_BITS-1 -: 2], idx[QB-1:0]);
      gy4_nxt[c] = grad_of(idx[ANGLE_BITS-1 -: 2] + 2'd1, idx[QB-1:0]);
      // The offset from the far corner is the fraction minus one.
      dx = c[0] ? $signed({1'b1, fx_4_r}) : $signed({1'b0, fx_4_r});
      dy = c[1] ? $signed({1'b1, fy_4_r}) : $signed({1'b0, fy_4_r});
      dsum = DP_W'(dx) * DP_W'(gx4_r[c]) + DP_W'(dy) * DP_W'(gy4_r[c]);
      dot5_nxt[c] = DOT_W'(dsum >>> GRAD_FRAC);
    end
  end

  assign sqx = 32'(pos.fx) * 32'(pos.fx);
  assign sqy = 32'(pos.fy) * 32'(pos.fy);
  assign fpx = (FRAC_W+FADE_W+1)'(w2x_1_r) * (FRAC_W+FADE_W+1)'(FADE_K - 18'({fx_1_r, 1'b0}));
  assign fpy = (FRAC_W+FADE_W+1)'(w2y_1_r) * (FRAC_W+FADE_W+1)'(FADE_K - 18'({fy_1_r, 1'b0}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[OCT_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    ha1_r   <= ha1_nxt;
    y0_1_r  <= pos.y0;
    fx_1_r  <= pos.fx;
    fy_1_r  <= pos.fy;
    w2x_1_r <= sqx[31:16];
    w2y_1_r <= sqy[31:16];

    ha2_r  <= ha1_r;
    hb2_r  <= hb2_nxt;
    fx_2_r <= fx_1_r;
    fy_2_r <= fy_1_r;
    sx_2_r <= fpx[FRAC_W +: FADE_W];
    sy_2_r <= fpy[FRAC_W +: FADE_W];

    hc3_r  <= hc3_nxt;
    fx_3_r <= fx_2_r;
    fy_3_r <= fy_2_r;
    sx_3_r <= sx_2_r;
    sy_3_r <= sy_2_r;

    gx4_r  <= gx4_nxt;
    gy4_r  <= gy4_nxt;
    fx_4_r <= fx_3_r;
    fy_4_r <= fy_3_r;
    sx_4_r <= sx_3_r;
    sy_4_r <= sy_3_r;

    dot5_r <= dot5_nxt;
    sx_5_r <= sx_4_r;
    sy_5_r <= sy_4_r;

    for (int i = 0; i < 2; i++) begin
      a06_r[i] <= dot5_r[2*i];
      df6_r[i] <= DF_W'(dot5_r[2*i+1]) - DF_W'(dot5_r[2*i]);
      a07_r[i] <= a06_r[i];
      p7_r[i]  <= P1_W'(df6_r[i]) * P1_W'($signed({1'b0, sx_6_r}));
    end
    sx_6_r <= sx_5_r;
    sy_6_r <= sy_5_r;
    sy_7_r <= sy_6_r;

    top8_r <= NW'(a07_r[0]) + NW'(p7_r[0] >>> FRAC_W);
    df8_r  <= (NW+1)'(NW'(a07_r[1]) + NW'(p7_r[1] >>> FRAC_W))
              - (NW+1)'(NW'(a07_r[0]) + NW'(p7_r[0] >>> FRAC_W));
    sy_8_r <= sy_7_r;

    top9_r <= top8_r;
    p9_r   <= P2_W'(df8_r) * P2_W'($signed({1'b0, sy_8_r}));

    noise_r <= top9_r + NW'(p9_r >>> FRAC_W);
  end

  assign out_valid = v_r[OCT_STAGES-1];
  assign noise     = noise_r;

endmodule

// ===== rtl/fgn_post.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_post: octave sum, gain, clamp and quantization
// Weights and sums the octave values, scales by 6/5, clamps to one and maps
// the result to an 8-bit height and a six-step level.
// ----------------------------------------------------------------------------
module fgn_post (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [fgn_pkg::NW-1:0] noise [fgn_pkg::OCTAVES],
  output logic                          out_valid,
  output fgn_pkg::out_t                 out_data
);
  import fgn_pkg::*;

  localparam int GROUPS   = (OCTAVES + 3) / 4;
  localparam int T_W      = SUM_W + 3;
  localparam int M_W      = 19;
  localparam int Q_W      = 2 * M_W;
  localparam int RECIP_SH = 21;
  localparam logic [M_W-1:0] RECIP5 = 19'd419431;
  localparam int CLAMP_LIM = 5 * ONE_Q16;

  logic [POST_STAGES-1:0] v_r;
  logic signed [SUM_W-1:0] gsum_r [GROUPS];
  logic signed [SUM_W-1:0] tot_r;
  logic [M_W-1:0]  mag_r;
  logic            neg3_r, big3_r, neg4_r, big4_r;
  logic [Q_W-1:0]  q_r;
  logic [7:0]      height_r;
  out_t            out_r;

  logic signed [SUM_W-1:0] gsum_nxt [GROUPS];
  logic signed [SUM_W-1:0] tot_nxt;
  logic [T_W-1:0]          mag_nxt;
  logic signed [T_W-1:0]   t_nxt;
  logic [FRAC_W:0]         qv;
  logic [FRAC_W+1:0]       u;
  logic [FRAC_W+8:0]       hp;
  logic [2:0]              level_nxt;

  always_comb begin
    logic signed [SUM_W-1:0] acc;
    for (int g = 0; g < GROUPS; g++) begin
      acc = '0;
      for (int j = 0; j < 4; j++) begin
        if (g * 4 + j < OCTAVES) acc = acc + SUM_W'(noise[g*4+j] >>> (g * 4 + j));
      end
      gsum_nxt[g] = acc;
    end
    tot_nxt = '0;
    for (int g = 0; g < GROUPS; g++) tot_nxt = tot_nxt + gsum_r[g];
  end

  assign t_nxt   = (T_W'(tot_r) <<< 2) + (T_W'(tot_r) <<< 1);
  assign mag_nxt = t_nxt[T_W-1] ? T_W'(-t_nxt) : T_W'(t_nxt);

  // Past five times one, the gain stage always clamps.
  assign qv = big4_r ? (FRAC_W+1)'(ONE_Q16) : q_r[RECIP_SH +: FRAC_W+1];
  assign u  = neg4_r ? (FRAC_W+2)'(ONE_Q16) - (FRAC_W+2)'(qv)
                     : (FRAC_W+2)'(ONE_Q16) + (FRAC_W+2)'(qv);
  assign hp = ((FRAC_W+9)'(u) << 8) - (FRAC_W+9)'(u);

  always_comb begin
    level_nxt = LEVEL_MAX;
    for (int i = LEVELS - 2; i >= 0; i--) begin
      if (height_r < LVL_THR[i]) level_nxt = 3'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[POST_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    gsum_r   <= gsum_nxt;
    tot_r    <= tot_nxt;
    mag_r    <= mag_nxt[M_W-1:0];
    neg3_r   <= t_nxt[T_W-1];
    big3_r   <= mag_nxt >= T_W'(CLAMP_LIM);
    q_r      <= Q_W'(mag_r) * Q_W'(RECIP5);
    neg4_r   <= neg3_r;
    big4_r   <= big3_r;
    height_r <= hp[FRAC_W+8 -: 8];
    out_r.height <= height_r;
    out_r.level  <= level_nxt;
  end

  assign out_valid = v_r[POST_STAGES-1];
  assign out_data  = out_r;

endmodule

// ===== rtl/fractal_gradient_noise_pixel_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal_gradient_noise_pixel_unit: 12-octave gradient noise per pixel
// Returns an 8-bit height and a six-step level for each grid coordinate.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_data (row, column) with start high; the item is taken at any
//   rising edge where start is high and busy is low. Busy is low whenever the
//   block is out of reset, so a new item can be given every clock.
//   After an item is taken and has passed through the divider, octave and
//   post stages, out_valid is high for one cycle with out_data holding its
//   height and level. Results leave in the order the items came in; the
//   receiver must take each result in the cycle it is shown.
//   Throughput is one item per clock. The path is seven divider stages, ten
//   stages per octave (three hash multiplies, the gradient table, the dot
//   products and two blend multiplies) and six stages of summing, gain,
//   clamp and quantization; all twelve octaves run side by side.
//   Configuration: cfg_we with cfg_index selects hash_seed (0) or
//   scale_divisor (1); write only while no item is in flight. A divisor of
//   zero acts as one. Reset (rst_n low, synchronous) restores seed 1 and
//   divisor 20 and empties the pipeline.
// ----------------------------------------------------------------------------
module fractal_gradient_noise_pixel_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  fgn_pkg::in_t                     in_data,
  output logic                             out_valid,
  output fgn_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [fgn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fgn_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fgn_pkg::*;

  logic [SEED_W-1:0] seed_r;
  logic [DIV_W-1:0]  scale_div_r;
  logic [DIV_W-1:0]  div_eff;
  logic              accept;
  logic              rv, cv;
  logic [QW-1:0]     rq, cq;
  logic [OCTAVES-1:0] ov;
  logic signed [NW-1:0] onoise [OCTAVES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= SEED_RESET;
      scale_div_r <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HASH_SEED: seed_r      <= cfg_data[SEED_W-1:0];
        REG_SCALE_DIV: scale_div_r <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // The block never holds items off; busy only covers reset.
  assign busy    = ~rst_n;
  assign accept  = start & ~busy;
  assign div_eff = (scale_div_r == '0) ? DIV_W'(1) : scale_div_r;

  // Row is the x axis of the noise, column the y axis.
  fgn_div u_div_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .coord     (in_data.row & COORD_W'(COORD_SPAN - 1)),
    .divisor   (div_eff),
    .out_valid (rv),
    .quot      (rq)
  );

  fgn_div u_div_col (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .coord     (in_data.column & COORD_W'(COORD_SPAN - 1)),
    .divisor   (div_eff),
    .out_valid (cv),
    .quot      (cq)
  );

  // Octave k uses the quotient shifted down by OCTAVES - 1 - k.
  for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
    logic [QW-1:0] px, py;
    oct_pos_t      pos;
    assign px     = rq >> (OCTAVES - 1 - k);
    assign py     = cq >> (OCTAVES - 1 - k);
    assign pos.x0 = HASH_W'(px[QW-1:FRAC_W]);
    assign pos.y0 = HASH_W'(py[QW-1:FRAC_W]);
    assign pos.fx = px[FRAC_W-1:0];
    assign pos.fy = py[FRAC_W-1:0];

    fgn_octave u_oct (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (rv & cv),
      .pos       (pos),
      .seed      (seed_r),
      .out_valid (ov[k]),
      .noise     (onoise[k])
    );
  end

  fgn_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ov[0]),
    .noise     (onoise),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without an item taken LATENCY cycles earlier");

  a_octaves_aligned : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ov) == 1'b0 || ov == '0 || OCTAVES == 1)
    else $error("octave lanes out of step");

  a_level_top : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.height >= LVL_THR[LEVELS-2]) == (out_data.level == LEVEL_MAX)))
    else $error("level does not match height");

  a_reset_empty : assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result left over from before reset");
`endif

endmodule
